[design/wrs_pkg.sv]
`default_nettype none

package wrs_pkg;

    // Sizing
    localparam int MAX_OPTIONS = 16;
    localparam int WEIGHT_BITS = 16;

    // Fixed field widths of the channels
    localparam int WEIGHT_IN_W = 16;
    localparam int RAND_W      = 31;
    localparam int CHOSEN_W    = 4;

    // Derived widths
    localparam int IDX_W   = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1;
    localparam int CNT_W   = $clog2(MAX_OPTIONS + 1);
    localparam int TOTAL_W = WEIGHT_BITS + IDX_W;
    localparam int STEP_W  = $clog2(RAND_W);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RAND_W - 1);

    // Select status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_ZERO = 1'b1;

    typedef struct packed {
        logic [WEIGHT_IN_W-1:0] weight_milli;
        logic                   is_last;
        logic [RAND_W-1:0]      random_word;
    } t_in_item;

    typedef struct packed {
        logic [CHOSEN_W-1:0] chosen_index;
        logic                select_status;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic load;       // take the input request
        logic init;       // set up remainder, walk and result
        logic div_step;   // one remainder bit
        logic walk_step;  // one stored weight
        logic finish;     // publish result, start a new set
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic total_zero;
        logic walk_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

[design/wrs_ctrl.sv]
`default_nettype none

module wrs_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_last,
    input  wire wrs_pkg::t_status i_status,
    output logic                  o_in_ready,
    output wrs_pkg::t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    logic [wrs_pkg::STEP_W-1:0]  r_step;
    logic [wrs_pkg::STEP_W-1:0]  n_step;
    logic                        w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = w_accept;
                if (w_accept && i_in_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.init = 1'b1;
                n_step     = '0;
                n_state    = i_status.total_zero ? S_FINISH : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == wrs_pkg::LAST_STEP) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

[design/wrs_dp.sv]
`default_nettype none

module wrs_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wrs_pkg::t_in_item i_in_item,
    input  wire logic              i_out_ready,
    input  wire wrs_pkg::t_cmd     i_cmd,
    output wrs_pkg::t_status       o_status,
    output logic                   o_out_valid,
    output wrs_pkg::t_out_item     o_out_item
);

    // Weight storage, written in load order
    logic [wrs_pkg::WEIGHT_BITS-1:0] r_store [wrs_pkg::MAX_OPTIONS];

    logic [wrs_pkg::TOTAL_W-1:0] r_total;
    logic [wrs_pkg::CNT_W-1:0]   r_count;
    logic [wrs_pkg::RAND_W-1:0]  r_dvd;
    logic [wrs_pkg::TOTAL_W-1:0] r_rem;
    logic [wrs_pkg::TOTAL_W-1:0] r_prefix;
    logic [wrs_pkg::IDX_W-1:0]   r_idx;
    logic [wrs_pkg::IDX_W-1:0]   r_sel_idx;
    logic                        r_sel_err;
    logic                        r_out_valid;
    wrs_pkg::t_out_item          r_out;

    logic [wrs_pkg::WEIGHT_BITS-1:0] w_weight;
    logic                            w_has_room;
    logic [wrs_pkg::TOTAL_W:0]       w_rem_sh;
    logic                            w_rem_ge;
    logic [wrs_pkg::TOTAL_W-1:0]     n_prefix;
    logic                            w_hit;
    logic                            w_at_end;

    assign w_weight   = wrs_pkg::WEIGHT_BITS'(i_in_item.weight_milli);
    assign w_has_room = (r_count < wrs_pkg::CNT_W'(wrs_pkg::MAX_OPTIONS));

    // Restoring remainder step
    assign w_rem_sh = {r_rem, r_dvd[wrs_pkg::RAND_W-1]};
    assign w_rem_ge = (w_rem_sh >= {1'b0, r_total});

    // Prefix walk step
    assign n_prefix = r_prefix + wrs_pkg::TOTAL_W'(r_store[r_idx]);
    assign w_hit    = (n_prefix >= r_rem);
    assign w_at_end = ((wrs_pkg::CNT_W'(r_idx) + wrs_pkg::CNT_W'(1)) == r_count);

    assign o_status.total_zero = (r_total == '0);
    assign o_status.walk_done  = w_hit || w_at_end;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // Store write
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_has_room) begin
            r_store[r_count[wrs_pkg::IDX_W-1:0]] <= w_weight;
        end
    end

    // Set bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_count <= '0;
        end else if (i_cmd.finish) begin
            r_total <= '0;
            r_count <= '0;
        end else if (i_cmd.load && w_has_room) begin
            r_total <= r_total + wrs_pkg::TOTAL_W'(w_weight);
            r_count <= r_count + 1'b1;
        end
    end

    // Remainder, walk and selection registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dvd <= i_in_item.random_word;
        end
        if (i_cmd.init) begin
            r_rem     <= '0;
            r_prefix  <= '0;
            r_idx     <= '0;
            r_sel_idx <= '0;
            r_sel_err <= (r_total == '0) ? wrs_pkg::STATUS_ZERO : wrs_pkg::STATUS_OK;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[wrs_pkg::RAND_W-2:0], 1'b0};
            r_rem <= w_rem_ge ? wrs_pkg::TOTAL_W'(w_rem_sh - {1'b0, r_total})
                              : wrs_pkg::TOTAL_W'(w_rem_sh);
        end
        if (i_cmd.walk_step) begin
            r_prefix <= n_prefix;
            r_idx    <= r_idx + 1'b1;
            if (w_hit) begin
                r_sel_idx <= r_idx;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.chosen_index  <= wrs_pkg::CHOSEN_W'(r_sel_idx);
            r_out.select_status <= r_sel_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // Never more weights held than there are slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wrs_pkg::CNT_W'(wrs_pkg::MAX_OPTIONS))
        else $error("weight count beyond capacity");

    // Reduced value is below the total once the walk runs
    a_rem_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_step |-> (r_rem < r_total))
        else $error("remainder not reduced below total");

    // A result is only published into a free output register
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a pending one");

    // Zero-total results always carry index zero
    a_err_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.select_status == wrs_pkg::STATUS_ZERO)
            |-> (r_out.chosen_index == '0))
        else $error("error result with nonzero index");
`endif

endmodule

`default_nettype wire

[design/weighted_random_selector.sv]
// Channel  | Signals                               | Payload
// ---------+---------------------------------------+------------------------------
// input    | i_in_valid / o_in_ready / i_in_item   | weight_milli, is_last, random_word
// output   | o_out_valid / i_out_ready / o_out_item| chosen_index, select_status
//
// A request without is_last is taken while idle; the block stays ready for the next.
// A last request is loaded, the total checked, the bit-serial remainder formed (one bit
// a cycle over the random word), the stored weights walked and the result published
// before the next request; a zero total skips the remainder and the walk.
// Reset (i_rst_n low, synchronous) empties the set and the output register.
// A stalled output holds the result; the block waits to publish a new one.
`default_nettype none

module weighted_random_selector (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire wrs_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output wrs_pkg::t_out_item      o_out_item
);

    wrs_pkg::t_cmd    w_cmd;
    wrs_pkg::t_status w_status;

    // Sequencer
    wrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_item.is_last),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // Storage, remainder, walk and output register
    wrs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int N_ITEMS     = 1300;
    localparam int IDLE_LIMIT  = 4000;
    localparam int TAIL_CYCLES = 60;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    wrs_pkg::t_in_item  i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    wrs_pkg::t_out_item o_out_item;

    weighted_random_selector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #1 i_clk = ~i_clk;

    // Requests waiting to be sent, and picks waiting to come back
    wrs_pkg::t_in_item  weight_requests[$];
    wrs_pkg::t_out_item pending_picks[$];

    // Predictor copy of the wheel
    logic [wrs_pkg::WEIGHT_BITS-1:0] wheel_weights [wrs_pkg::MAX_OPTIONS];
    int unsigned wheel_total = 0;
    int unsigned wheel_count = 0;

    int mismatches    = 0;
    int items_queued  = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int stall_mode    = 0;
    int mode_left     = 0;
    int idle_cycles   = 0;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $time);
    endtask

    // Load one weight; a last request spins the wheel and queues the pick
    task automatic spin_wheel(input wrs_pkg::t_in_item req);
        wrs_pkg::t_out_item pick;
        int unsigned        target;
        int unsigned        prefix;
        int unsigned        slot;
        if (wheel_count < wrs_pkg::MAX_OPTIONS) begin
            wheel_weights[wheel_count] = req.weight_milli[wrs_pkg::WEIGHT_BITS-1:0];
            wheel_total += req.weight_milli[wrs_pkg::WEIGHT_BITS-1:0];
            wheel_count++;
        end
        if (!req.is_last) return;
        pick.chosen_index  = '0;
        pick.select_status = wrs_pkg::STATUS_ZERO;
        if (wheel_total != 0) begin
            // first slot whose prefix reaches the reduced word
            target = req.random_word % wheel_total;
            slot   = 0;
            prefix = wheel_weights[0];
            while (prefix < target && slot + 1 < wheel_count) begin
                slot++;
                prefix += wheel_weights[slot];
            end
            pick.chosen_index  = wrs_pkg::CHOSEN_W'(slot);
            pick.select_status = wrs_pkg::STATUS_OK;
        end
        pending_picks = {pending_picks, pick};
        wheel_total = 0;
        wheel_count = 0;
    endtask

    task automatic push_request(input logic [wrs_pkg::WEIGHT_IN_W-1:0] w, input logic last,
                                input logic [wrs_pkg::RAND_W-1:0] word);
        wrs_pkg::t_in_item req;
        req.weight_milli = w;
        req.is_last      = last;
        req.random_word  = word;
        weight_requests = {weight_requests, req};
        items_queued++;
    endtask

    function automatic logic [wrs_pkg::WEIGHT_IN_W-1:0] draw_weight(input int flavor);
        case (flavor)
            0: return wrs_pkg::WEIGHT_IN_W'($urandom);
            1: return wrs_pkg::WEIGHT_IN_W'($urandom_range(3, 0));
            2: return '0;
            3: return ($urandom_range(1, 0) != 0) ? '1 : '0;
            default: return ($urandom_range(7, 0) == 0) ? wrs_pkg::WEIGHT_IN_W'($urandom)
                                                         : '0;
        endcase
    endfunction

    // One full set of weights; the word on the last request is shaped by word_kind
    task automatic queue_set(input int n, input int flavor, input int word_kind);
        int unsigned                      sum;
        int                               k;
        logic [wrs_pkg::WEIGHT_IN_W-1:0]  w;
        logic [wrs_pkg::RAND_W-1:0]       word;
        sum = 0;
        for (k = 0; k < n; k++) begin
            w = draw_weight(flavor);
            if (k < wrs_pkg::MAX_OPTIONS) sum += w;
            word = wrs_pkg::RAND_W'($urandom);
            if (k == n - 1) begin
                case (word_kind)
                    1: word = '0;
                    2: word = '1;
                    3: if (sum != 0)
                        word = wrs_pkg::RAND_W'(sum *
                                   $urandom_range(32'h7FFF_FFFF / sum, 0));
                    4: if (sum != 0) word = wrs_pkg::RAND_W'(sum - 1);
                    5: word = wrs_pkg::RAND_W'($urandom_range(sum + 4, 0));
                    default: ;
                endcase
            end
            push_request(w, k == n - 1, word);
        end
    endtask

    // Sender: bursts of requests separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && !o_in_ready)) begin
            if (i_in_valid) weight_requests.pop_front();
            if (gap_left > 0 || weight_requests.size() == 0) begin
                if (gap_left > 0) gap_left--;
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_in_item  <= weight_requests[0];
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(40, 1);
                    gap_left   = ($urandom_range(1, 0) == 0) ? 0 : $urandom_range(60, 1);
                end
            end
        end
    end

    // Predictor runs on every accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) spin_wheel(i_in_item);
    end

    // Receiver: stall pattern is redrawn whenever its mode runs out
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(3, 0);
            mode_left  = $urandom_range(400, 50);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(1, 0) != 0);
            2: i_out_ready <= ($urandom_range(9, 0) == 0);
            default: i_out_ready <= ($urandom_range(3, 0) != 0);
        endcase
    end

    // Result check against the oldest expected pick
    always @(posedge i_clk) begin : pick_check
        wrs_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_picks.size() == 0) begin
                report_mismatch("unexpected pick, index", o_out_item.chosen_index, 0);
            end else begin
                want = pending_picks.pop_front();
                if (o_out_item.chosen_index !== want.chosen_index)
                    report_mismatch("chosen_index", o_out_item.chosen_index,
                                    want.chosen_index);
                if (o_out_item.select_status !== want.select_status)
                    report_mismatch("select_status", o_out_item.select_status,
                                    want.select_status);
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // Directed: extremes of weight and word
        push_request(16'hFFFF, 1'b1, '1);
        push_request(16'h0000, 1'b1, '0);
        // leading zero weight is chosen when the reduced word is zero
        push_request(16'd0, 1'b0, wrs_pkg::RAND_W'($urandom));
        push_request(16'd5, 1'b0, wrs_pkg::RAND_W'($urandom));
        push_request(16'd7, 1'b1, '0);
        // reduced word equal to total minus one lands on the last nonzero slot
        push_request(16'd3, 1'b0, wrs_pkg::RAND_W'($urandom));
        push_request(16'd0, 1'b0, wrs_pkg::RAND_W'($urandom));
        push_request(16'd4, 1'b1, wrs_pkg::RAND_W'(6));
        // overflow: weight past a full wheel is dropped, leaving a zero total
        repeat (wrs_pkg::MAX_OPTIONS) push_request(16'd0, 1'b0, wrs_pkg::RAND_W'($urandom));
        push_request(16'hFFFF, 1'b1, wrs_pkg::RAND_W'($urandom));

        // Random sets, mostly within capacity, some overflowing
        while (items_queued < N_ITEMS) begin
            queue_set(($urandom_range(9, 0) == 0) ? $urandom_range(24, 17)
                                                  : $urandom_range(wrs_pkg::MAX_OPTIONS, 1),
                      $urandom_range(4, 0), $urandom_range(5, 0));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk); while (weight_requests.size() != 0);
        while (pending_picks.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_picks.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
